// ----- rtl/bpi_pkg.sv -----
// ----------------------------------------------------------------------------
// bpi_pkg
// Shared types and constants for the Bezier progress interpolator.
// ----------------------------------------------------------------------------
package bpi_pkg;

   localparam int COORD_W    = 16;                   // signed Q8.8 component
   localparam int NUM_LANES  = 4;                    // x, y, z, w
   localparam int LANE_W     = $clog2(NUM_LANES);
   localparam int PROG_FRAC  = 16;                   // progress fraction bits
   localparam int PROG_W     = PROG_FRAC + 1;        // 0 .. 1.0 inclusive
   localparam int ELAPSED_W  = 16;
   localparam int DUR_W      = 16;
   localparam int ACTION_W   = 2;
   localparam int DIV_W      = ELAPSED_W + PROG_FRAC; // |elapsed| * ONE
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int SUM_W      = DIV_W + 2;             // progress + signed delta
   localparam int PROD_W     = (COORD_W + 1) + (PROG_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = NUM_LANES * COORD_W;

   localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROG_FRAC;

   typedef logic signed [COORD_W-1:0]               coord_type;
   typedef logic [NUM_LANES-1:0][COORD_W-1:0]       point_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADVANCE = 2'd0,
      ACT_RESET   = 2'd1,
      ACT_FILL    = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START    = 3'd0,
      REG_CONTROL  = 3'd1,
      REG_END      = 3'd2,
      REG_DURATION = 3'd3,
      REG_MODE     = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CLAMP,
      ST_MULT,
      ST_ACCUM,
      ST_REPORT
   } state_type;

   // which lerp of the de Casteljau triple is in flight
   typedef enum logic [1:0] {
      PH_NEAR,    // start -> control (or start -> end when linear)
      PH_FAR,     // control -> end
      PH_BLEND    // p0 -> p1
   } phase_type;

endpackage

// ----- rtl/bpi_req_if.sv -----
// ----------------------------------------------------------------------------
// bpi_req_if
// Request channel: action code and elapsed time step.
// ----------------------------------------------------------------------------
interface bpi_req_if import bpi_pkg::*; ();

   logic                         valid;
   logic                         ready;
   logic [ACTION_W-1:0]          action;
   logic signed [ELAPSED_W-1:0]  elapsed;

   modport source (output valid, output action, output elapsed, input ready);
   modport sink   (input valid, input action, input elapsed, output ready);

endinterface

// ----- rtl/bpi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bpi_rsp_if
// Response channel: position, progress and finished flag.
// ----------------------------------------------------------------------------
interface bpi_rsp_if import bpi_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_y;
   logic signed [COORD_W-1:0]  pos_z;
   logic signed [COORD_W-1:0]  pos_w;
   logic [PROG_W-1:0]          progress_out;
   logic                       finished;

   modport source (output valid, output pos_x, output pos_y, output pos_z, output pos_w,
                   output progress_out, output finished, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, input pos_w,
                   input progress_out, input finished, output ready);

endinterface

// ----- rtl/bezier_progress_interpolator.sv -----
// ----------------------------------------------------------------------------
// bezier_progress_interpolator
// Moves a four-component Q8.8 point along a linear or quadratic Bezier path.
// ----------------------------------------------------------------------------
// Usage: each request item yields exactly one response item. A reset item
// (progress 0, position = start) or a fill item (progress 1.0, position = end)
// passes through ST_REPORT and is loaded into the response register as soon
// as that register is empty or being read. An advance item first runs the
// bit-serial restoring divider that forms elapsed * 65536 / duration, then
// the clamp state, then a multiply and an accumulate state per lerp on the
// single shared 17x18 multiplier - 4 lerps for a line (curve_mode 0), 12 for
// the de Casteljau quadratic (curve_mode 1) - then ST_REPORT loads the
// response. The block takes one item at a time; a finished response waits in
// its own register, so the next request is taken while it is still unread.
// Program start/control/end, duration and mode only while idle; writing them
// does not move the point, so follow a path change with a reset item.
// A duration of 0 acts as 1. Progress is unsigned Q1.16 clamped to [0, 1.0].
// ----------------------------------------------------------------------------
module bezier_progress_interpolator import bpi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bpi_req_if.sink                req_ch,
   bpi_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------- registers ----------------
   state_type                state_ff, state_in;

   point_type                start_ff, start_in;
   point_type                ctrl_ff, ctrl_in;
   point_type                end_ff, end_in;
   logic [DUR_W-1:0]         dur_ff, dur_in;
   logic                     mode_ff, mode_in;

   logic [PROG_W-1:0]        progress_ff, progress_in;
   coord_type                pos_ff [NUM_LANES];
   coord_type                pos_in [NUM_LANES];

   // divider: quo_ff starts as the dividend and fills with quotient bits
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [DUR_W-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;

   // lerp sequencer and shared multiplier
   logic [LANE_W-1:0]        lane_ff, lane_in;
   phase_type                phase_ff, phase_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   coord_type                a_ff, a_in;
   coord_type                p0_ff, p0_in;
   coord_type                p1_ff, p1_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   coord_type                rsp_pos_ff [NUM_LANES];
   coord_type                rsp_pos_in [NUM_LANES];
   logic [PROG_W-1:0]        rsp_prog_ff, rsp_prog_in;

   // ---------------- control strobes ----------------
   logic                     req_ready;
   logic                     req_fire;
   logic                     rsp_load;
   logic                     div_last;
   logic                     op_last;
   phase_type                last_phase;

   // ---------------- datapath helpers ----------------
   logic [DUR_W-1:0]         dur_eff;
   logic [ELAPSED_W-1:0]     elapsed_mag;
   logic [DUR_W:0]           rem_sh;
   logic [DUR_W+1:0]         trial;
   logic                     q_bit;
   logic signed [SUM_W-1:0]  delta;
   logic signed [SUM_W-1:0]  sum;
   logic [PROG_W-1:0]        clamped;
   coord_type                op_a;
   coord_type                op_b;
   logic signed [COORD_W:0]  op_diff;
   logic signed [PROD_W-1:0] scaled;
   coord_type                lerp_res;

   assign dur_eff     = (dur_ff == '0) ? DUR_W'(1) : dur_ff;
   assign elapsed_mag = req_ch.elapsed[ELAPSED_W-1] ? (~req_ch.elapsed + ELAPSED_W'(1))
                                                    : req_ch.elapsed;

   // one restoring step: shift in the next dividend bit, try the subtract
   assign rem_sh = {rem_ff, quo_ff[DIV_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dur_eff};
   assign q_bit  = ~trial[DUR_W+1];

   // progress + signed quotient, clamped to [0, ONE]
   assign delta = neg_ff ? -$signed(SUM_W'(quo_ff)) : $signed(SUM_W'(quo_ff));
   assign sum   = delta + $signed(SUM_W'(progress_ff));

   always_comb begin : clamp_sum
      clamped = sum[PROG_W-1:0];
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > $signed(SUM_W'(PROG_ONE))) begin
         clamped = PROG_ONE;
      end
   end

   // lerp operands: a + floor((b - a) * t / ONE)
   always_comb begin : operand_select
      op_a = coord_type'(start_ff[lane_ff]);
      op_b = coord_type'(end_ff[lane_ff]);
      if (mode_ff) begin
         unique case (phase_ff)
            PH_NEAR: begin
               op_b = coord_type'(ctrl_ff[lane_ff]);
            end
            PH_FAR: begin
               op_a = coord_type'(ctrl_ff[lane_ff]);
            end
            PH_BLEND: begin
               op_a = p0_ff;
               op_b = p1_ff;
            end
            default: begin
               op_a = p0_ff;
               op_b = p1_ff;
            end
         endcase
      end
   end

   assign op_diff  = {op_b[COORD_W-1], op_b} - {op_a[COORD_W-1], op_a};
   assign scaled   = prod_ff >>> PROG_FRAC;           // floor toward minus infinity
   assign lerp_res = coord_type'(a_ff + scaled[COORD_W-1:0]);

   assign last_phase = mode_ff ? PH_BLEND : PH_NEAR;

   // ---------------- FSM outputs ----------------
   always_comb begin : fsm_outputs
      req_ready = (state_ff == ST_IDLE);
      rsp_load  = (state_ff == ST_REPORT) && (!rsp_valid_ff || rsp_ch.ready);
      div_last  = (cnt_ff == DIV_CNT_W'(DIV_W - 1));
      op_last   = (lane_ff == LANE_W'(NUM_LANES - 1)) && (phase_ff == last_phase);
   end

   assign req_fire = req_ch.valid && req_ready;

   // ---------------- FSM next state ----------------
   always_comb begin : fsm_next
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (action_type'(req_ch.action) == ACT_ADVANCE) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_last) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = op_last ? ST_REPORT : ST_MULT;
         end
         ST_REPORT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin : datapath_next
      start_in    = start_ff;
      ctrl_in     = ctrl_ff;
      end_in      = end_ff;
      dur_in      = dur_ff;
      mode_in     = mode_ff;
      progress_in = progress_ff;
      pos_in      = pos_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      lane_in     = lane_ff;
      phase_in    = phase_ff;
      prod_in     = prod_ff;
      a_in        = a_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_prog_in = rsp_prog_ff;

      // the user must issue register writes only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_START:    start_in = csr_wdata;
            REG_CONTROL:  ctrl_in  = csr_wdata;
            REG_END:      end_in   = csr_wdata;
            REG_DURATION: dur_in   = csr_wdata[DUR_W-1:0];
            REG_MODE:     mode_in  = csr_wdata[0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               quo_in   = {elapsed_mag, PROG_FRAC'(0)};
               rem_in   = '0;
               cnt_in   = '0;
               neg_in   = req_ch.elapsed[ELAPSED_W-1];
               lane_in  = '0;
               phase_in = PH_NEAR;
               unique case (action_type'(req_ch.action))
                  ACT_ADVANCE: ;
                  ACT_RESET: begin
                     progress_in = '0;
                     for (int k = 0; k < NUM_LANES; k++) begin
                        pos_in[k] = coord_type'(start_ff[k]);
                     end
                  end
                  ACT_FILL: begin
                     progress_in = PROG_ONE;
                     for (int k = 0; k < NUM_LANES; k++) begin
                        pos_in[k] = coord_type'(end_ff[k]);
                     end
                  end
                  default: ;   // unused code: report current state
               endcase
            end
         end
         ST_DIVIDE: begin
            quo_in = {quo_ff[DIV_W-2:0], q_bit};
            rem_in = q_bit ? trial[DUR_W-1:0] : rem_sh[DUR_W-1:0];
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
         ST_CLAMP: begin
            progress_in = clamped;
         end
         ST_MULT: begin
            prod_in = op_diff * $signed({1'b0, progress_ff});
            a_in    = op_a;
         end
         ST_ACCUM: begin
            if (!mode_ff || phase_ff == PH_BLEND) begin
               pos_in[lane_ff] = lerp_res;
            end else if (phase_ff == PH_NEAR) begin
               p0_in = lerp_res;
            end else begin
               p1_in = lerp_res;
            end
            if (phase_ff == last_phase) begin
               phase_in = PH_NEAR;
               lane_in  = lane_ff + LANE_W'(1);
            end else begin
               phase_in = phase_type'(phase_ff + 2'd1);
            end
         end
         ST_REPORT: begin
            if (rsp_load) begin
               rsp_pos_in  = pos_ff;
               rsp_prog_in = progress_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);

   // ---------------- registers: control and path state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         ctrl_ff      <= '0;
         end_ff       <= '0;
         dur_ff       <= DUR_W'(1);
         mode_ff      <= 1'b0;
         progress_ff  <= '0;
         cnt_ff       <= '0;
         lane_ff      <= '0;
         phase_ff     <= PH_NEAR;
         for (int k = 0; k < NUM_LANES; k++) begin
            pos_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         ctrl_ff      <= ctrl_in;
         end_ff       <= end_in;
         dur_ff       <= dur_in;
         mode_ff      <= mode_in;
         progress_ff  <= progress_in;
         cnt_ff       <= cnt_in;
         lane_ff      <= lane_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
      end
   end

   // ---------------- registers: payload ----------------
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      a_ff        <= a_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_prog_ff <= rsp_prog_in;
   end

   // ---------------- ports ----------------
   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pos_x        = rsp_pos_ff[0];
   assign rsp_ch.pos_y        = rsp_pos_ff[1];
   assign rsp_ch.pos_z        = rsp_pos_ff[2];
   assign rsp_ch.pos_w        = rsp_pos_ff[3];
   assign rsp_ch.progress_out = rsp_prog_ff;
   assign rsp_ch.finished     = (rsp_prog_ff == PROG_ONE);

   // ---------------- assertions ----------------
   // progress never leaves [0, ONE]
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= PROG_ONE)
      else $error("progress above one");

   // restoring divider keeps its partial remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < dur_eff))
      else $error("divider remainder out of range");

   // a fill item lands progress at one, a reset item at zero
   a_fill_sets_one: assert property (@(posedge clock) disable iff (reset)
      (req_fire && action_type'(req_ch.action) == ACT_FILL) |=> (progress_ff == PROG_ONE))
      else $error("fill did not set progress");

   a_reset_sets_zero: assert property (@(posedge clock) disable iff (reset)
      (req_fire && action_type'(req_ch.action) == ACT_RESET) |=> (progress_ff == '0))
      else $error("reset item did not clear progress");

   // the lerp sequencer only runs after the divider has finished
   a_mult_after_clamp: assert property (@(posedge clock) disable iff (reset)
      ($rose(state_ff == ST_MULT) && $past(state_ff) != ST_ACCUM) |->
         ($past(state_ff) == ST_CLAMP))
      else $error("multiply entered without clamp");

endmodule
